// File: design/ubd_pkg.sv
`default_nettype none

package ubd_pkg;

  // Counter width; lengths wider than the counter saturate on load
  localparam int CNT_W = 16;
  localparam int CFG_W = 16;
  localparam int REG_IDX_W = 2;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CFG_W-1:0] cfg_word_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  typedef logic signed [1:0] step_t;

  localparam reg_idx_t REG_DEBOUNCE     = reg_idx_t'(0);
  localparam reg_idx_t REG_FIRST_REPEAT = reg_idx_t'(1);
  localparam reg_idx_t REG_NEXT_REPEAT  = reg_idx_t'(2);

  localparam cfg_word_t DEBOUNCE_RESET     = cfg_word_t'(1250);
  localparam cfg_word_t FIRST_REPEAT_RESET = cfg_word_t'(6000);
  localparam cfg_word_t NEXT_REPEAT_RESET  = cfg_word_t'(2000);

  localparam step_t STEP_NONE = 2'sb00;
  localparam step_t STEP_UP   = 2'sb01;
  localparam step_t STEP_DOWN = 2'sb11;

  // Clamp a length to the counter range
  function automatic cnt_t fit(input cfg_word_t v);
    cfg_word_t hi;
    begin
      hi = v >> CNT_W;
      fit = (hi != '0) ? '1 : cnt_t'(v);
    end
  endfunction

endpackage

`default_nettype wire

// File: design/ubd_sample_if.sv
`default_nettype none

interface ubd_sample_if;
  logic valid;
  logic ready;
  logic tick_passed;
  logic down_released;
  logic up_released;

  modport source (output valid, output tick_passed, output down_released,
                  output up_released, input ready);
  modport sink (input valid, input tick_passed, input down_released,
                input up_released, output ready);
endinterface

`default_nettype wire

// File: design/ubd_result_if.sv
`default_nettype none

interface ubd_result_if
  import ubd_pkg::*;
;
  logic valid;
  logic ready;
  step_t step;

  modport source (output valid, output step, input ready);
  modport sink (input valid, input step, output ready);
endinterface

`default_nettype wire

// File: design/ubd_cfg_if.sv
`default_nettype none

interface ubd_cfg_if
  import ubd_pkg::*;
;
  logic valid;
  logic ready;
  reg_idx_t index;
  cfg_word_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/updown_button_debounce_autorepeat.sv
// A step is registered and reaches the result channel the cycle after its sample.
// Throughput: one sample per cycle; the only limit is the single result register,
// which takes a new sample while its current step is being taken.
// Reset (rst, synchronous, active high): counters and repeat flag clear, lengths
// return to 1250 / 6000 / 2000, result channel empties.
`default_nettype none

module updown_button_debounce_autorepeat
  import ubd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  ubd_cfg_if.sink     cfg,
  ubd_sample_if.sink  sample,
  ubd_result_if.source result
);

  cfg_word_t debounce_length;
  cfg_word_t first_repeat_length;
  cfg_word_t next_repeat_length;

  cnt_t debounce_count, debounce_count_next;
  cnt_t repeat_count, repeat_count_next;
  logic repeat_active, repeat_active_next;

  logic  result_valid;
  step_t result_step;
  step_t step_next;

  logic sample_xfer;
  logic down_pressed, up_pressed;
  cnt_t dc_tick, rc_tick;
  logic ra_tick;

  assign cfg.ready    = 1'b1;
  assign sample.ready = !result_valid || result.ready;
  assign sample_xfer  = sample.valid && sample.ready;
  assign result.valid = result_valid;
  assign result.step  = result_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_length     <= DEBOUNCE_RESET;
      first_repeat_length <= FIRST_REPEAT_RESET;
      next_repeat_length  <= NEXT_REPEAT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DEBOUNCE:     debounce_length     <= cfg.data;
        REG_FIRST_REPEAT: first_repeat_length <= cfg.data;
        REG_NEXT_REPEAT:  next_repeat_length  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    down_pressed = !sample.down_released;
    up_pressed   = !sample.up_released;

    // Advance timers by one tick first; debounce reloads while a button is held
    dc_tick = debounce_count;
    ra_tick = repeat_active;
    rc_tick = repeat_count;
    if (sample.tick_passed) begin
      if (debounce_count != '0) begin
        if (!down_pressed && !up_pressed) begin
          dc_tick = debounce_count - cnt_t'(1);
          if (dc_tick == '0) ra_tick = 1'b0;
        end else begin
          dc_tick = fit(debounce_length);
        end
      end
      if (repeat_count != '0) rc_tick = repeat_count - cnt_t'(1);
    end

    step_next           = STEP_NONE;
    debounce_count_next = dc_tick;
    repeat_count_next   = rc_tick;
    repeat_active_next  = ra_tick;
    if (dc_tick == '0 || rc_tick == '0) begin
      if (down_pressed) step_next = STEP_DOWN;
      else if (up_pressed) step_next = STEP_UP;
      if (down_pressed || up_pressed) begin
        debounce_count_next = fit(debounce_length);
        repeat_active_next  = 1'b1;
        repeat_count_next   = ra_tick ? fit(next_repeat_length) : fit(first_repeat_length);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count <= '0;
      repeat_count   <= '0;
      repeat_active  <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (sample_xfer) begin
        debounce_count <= debounce_count_next;
        repeat_count   <= repeat_count_next;
        repeat_active  <= repeat_active_next;
        result_valid   <= 1'b1;
      end else if (result.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_xfer) result_step <= step_next;
  end

  a_step_sets_repeat: assert property (@(posedge clk) disable iff (rst)
    sample_xfer && step_next != STEP_NONE |=> repeat_active && result_step == $past(step_next))
    else $error("step taken without repeat flag set");

  a_debounce_expiry: assert property (@(posedge clk) disable iff (rst)
    sample_xfer && sample.tick_passed && debounce_count == cnt_t'(1)
      && sample.down_released && sample.up_released
      |=> !repeat_active && debounce_count == '0)
    else $error("debounce expiry did not clear repeat flag");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> result_valid && !result.ready)
    else $error("sample stalled with room in result register");

  a_result_from_sample: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_xfer))
    else $error("result appeared without a sample transfer");

endmodule

`default_nettype wire
